### rtl/dbsf_pkg.sv
// ----------------------------------------------------------------------------
// dbsf_pkg: shared types and constants of the battery sample filter
// Field widths, register indexes, reset values, sequencer states and the
// reciprocal constants of the divide by 1000.
// ----------------------------------------------------------------------------
package dbsf_pkg;

  // Default sizes of the averaging datapath
  localparam int unsigned DBSF_RUN_COUNT_WIDTH = 8;
  localparam int unsigned DBSF_FRACTION_BITS   = 16;

  // Fixed field widths
  localparam int unsigned MV_W     = 15;
  localparam int unsigned MA_FLD_W = 16;
  localparam int unsigned WGT_W    = 16;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned SHUNT_W  = 10;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned SH_W     = 26;
  localparam int unsigned SRCO_W   = 17;
  localparam int unsigned PB_W     = 22;
  localparam int unsigned PS_W     = 23;

  // Internal value widths
  localparam int unsigned V_W   = 16;  // rounded voltage, signed, always >= 0
  localparam int unsigned SRC_W = 18;  // source voltage before truncation

  // Divide by 1000: q0 = (n * DIV_RECIP) >> DIV_SHIFT is exact or one short
  localparam int unsigned ABS_W      = 33;
  localparam int unsigned DIV_SHIFT  = 33;
  localparam int unsigned RECIP_W    = 24;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 24'd8589934;
  localparam int unsigned Q_W        = 24;
  localparam logic [ABS_W:0] DIVISOR = 34'd1000;

  // Register reset values
  localparam logic [MV_W-1:0]    RST_MIN_MV   = 15'd6000;
  localparam logic [MV_W-1:0]    RST_MAX_MV   = 15'd26000;
  localparam logic [MV_W-1:0]    RST_STEP_MV  = 15'd2000;
  localparam logic [WGT_W-1:0]   RST_V_WGT    = 16'd6554;
  localparam logic [WGT_W-1:0]   RST_I_WGT    = 16'd13107;
  localparam logic [CNT_W-1:0]   RST_CONFIRM  = 8'd3;
  localparam logic [CNT_W-1:0]   RST_RECOVER  = 8'd3;
  localparam logic [SHUNT_W-1:0] RST_SHUNT    = 10'd100;

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_MIN_MV  = 4'd0,
    REG_MAX_MV  = 4'd1,
    REG_STEP_MV = 4'd2,
    REG_V_WGT   = 4'd3,
    REG_I_WGT   = 4'd4,
    REG_CONFIRM = 4'd5,
    REG_RECOVER = 4'd6,
    REG_SHUNT   = 4'd7
  } reg_idx_e;

  // Sequencer states, one-hot
  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_EVAL   = 14'b00000000000010,
    S_MUL_V  = 14'b00000000000100,
    S_MUL_I  = 14'b00000000001000,
    S_UPD_I  = 14'b00000000010000,
    S_ROUND  = 14'b00000000100000,
    S_MUL_SH = 14'b00000001000000,
    S_ABS    = 14'b00000010000000,
    S_DMUL   = 14'b00000100000000,
    S_DFIX   = 14'b00001000000000,
    S_DSGN   = 14'b00010000000000,
    S_MUL_PB = 14'b00100000000000,
    S_MUL_PS = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_e;

  // Which quotient the divider is producing
  typedef enum logic [1:0] {
    DIV_SH = 2'd0,
    DIV_PB = 2'd1,
    DIV_PS = 2'd2
  } div_sel_e;

endpackage

### rtl/debounced_battery_sample_filter_top.sv
// ----------------------------------------------------------------------------
// debounced_battery_sample_filter_top: debounced battery sample filter
// Rejects implausible samples, keeps two moving averages and reports the
// filtered values, shunt and source voltage, powers and a validity flag.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid_i / in_stall_o carry one sample request (read_ok,
//   bus mV, current mA). Output channel: out_valid_o / out_stall_i carry one
//   result per sample. A transfer happens when valid is high and stall low.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i; indexes
//   above 7 are ignored. Write only while the block is idle.
//   Datapath: one shared 34x25 multiplier does the two average updates, the
//   shunt product, both power products and three divides by 1000 (reciprocal
//   multiply plus one correction). A good sample after priming first updates
//   both averages; the priming sample and a bad sample after priming start at
//   the rounding; a bad sample before priming goes straight to the result.
//   One sample is in work at a time; in_stall_o is high until the result has
//   been moved to the output register, so a new request is taken only after
//   the previous sample has left the sequencer.
//   The output register holds a result while out_stall_i is high; the next
//   sample is accepted and computed meanwhile and waits in its final state
//   until the register is free.
//   Reset: registers return to their defaults, averages are unprimed, the
//   validity flag is set, no result is pending.
// ----------------------------------------------------------------------------
module debounced_battery_sample_filter_top
  import dbsf_pkg::*;
#(
  parameter int unsigned RUN_COUNT_WIDTH = DBSF_RUN_COUNT_WIDTH,
  parameter int unsigned FRACTION_BITS   = DBSF_FRACTION_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_W-1:0]          cfg_wdata_i,
  // sample requests
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      read_ok_i,
  input  logic [MV_W-1:0]           bus_millivolt_i,
  input  logic signed [MA_FLD_W-1:0] current_milliamp_i,
  // results
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [MV_W-1:0]           filtered_bus_millivolt_o,
  output logic signed [MA_FLD_W-1:0] filtered_current_milliamp_o,
  output logic signed [SH_W-1:0]    shunt_microvolt_o,
  output logic signed [SRCO_W-1:0]  source_millivolt_o,
  output logic signed [PB_W-1:0]    bus_power_milliwatt_o,
  output logic signed [PS_W-1:0]    source_power_milliwatt_o,
  output logic                      reading_valid_o
);

  localparam int unsigned F     = FRACTION_BITS;
  localparam int unsigned RW    = RUN_COUNT_WIDTH;
  localparam int unsigned VA_W  = MV_W + F;
  localparam int unsigned IA_W  = MA_FLD_W + F;
  localparam int unsigned D_W   = MA_FLD_W + F + 1;
  localparam int unsigned MA_W  = (D_W > ABS_W + 1) ? D_W : ABS_W + 1;
  localparam int unsigned MB_W  = RECIP_W + 1;
  localparam int unsigned P_W   = MA_W + MB_W;
  localparam int unsigned CMP_W = (RW > CNT_W) ? RW : CNT_W;

  // Configuration registers
  logic [MV_W-1:0]    min_mv_q, max_mv_q, step_mv_q;
  logic [WGT_W-1:0]   v_wgt_q, i_wgt_q;
  logic [CNT_W-1:0]   confirm_q, recover_q;
  logic [SHUNT_W-1:0] shunt_q;

  // Sequencer and state
  state_e   state_q, state_d;
  div_sel_e div_sel_q;
  logic                   ok_q;
  logic [MV_W-1:0]        bus_q;
  logic signed [MA_FLD_W-1:0] cur_q;
  logic [VA_W-1:0]        vavg_q;
  logic signed [IA_W-1:0] iavg_q;
  logic                   primed_q;
  logic [RW-1:0]          bad_q, good_q;
  logic                   valid_flag_q;

  // Datapath registers
  logic signed [P_W-1:0]      prod_q;
  logic [ABS_W-1:0]           abs_q;
  logic                       neg_q;
  logic [Q_W-1:0]             quot_q;
  logic signed [V_W-1:0]      v_q;
  logic signed [MA_FLD_W-1:0] i_q;
  logic signed [SH_W-1:0]     sh_q;
  logic signed [SRC_W-1:0]    src_q;
  logic signed [PB_W-1:0]     pb_q;
  logic signed [PS_W-1:0]     ps_q;

  // Output register
  logic                       out_valid_q;
  logic [MV_W-1:0]            out_bus_q;
  logic signed [MA_FLD_W-1:0] out_cur_q;
  logic signed [SH_W-1:0]     out_sh_q;
  logic signed [SRCO_W-1:0]   out_src_q;
  logic signed [PB_W-1:0]     out_pb_q;
  logic signed [PS_W-1:0]     out_ps_q;
  logic                       out_rv_q;

  logic in_acc, out_acc, out_load;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_mv_q  <= RST_MIN_MV;
      max_mv_q  <= RST_MAX_MV;
      step_mv_q <= RST_STEP_MV;
      v_wgt_q   <= RST_V_WGT;
      i_wgt_q   <= RST_I_WGT;
      confirm_q <= RST_CONFIRM;
      recover_q <= RST_RECOVER;
      shunt_q   <= RST_SHUNT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_MV:  min_mv_q  <= cfg_wdata_i[MV_W-1:0];
        REG_MAX_MV:  max_mv_q  <= cfg_wdata_i[MV_W-1:0];
        REG_STEP_MV: step_mv_q <= cfg_wdata_i[MV_W-1:0];
        REG_V_WGT:   v_wgt_q   <= cfg_wdata_i[WGT_W-1:0];
        REG_I_WGT:   i_wgt_q   <= cfg_wdata_i[WGT_W-1:0];
        REG_CONFIRM: confirm_q <= cfg_wdata_i[CNT_W-1:0];
        REG_RECOVER: recover_q <= cfg_wdata_i[CNT_W-1:0];
        REG_SHUNT:   shunt_q   <= cfg_wdata_i[SHUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sample check and run counters
  // --------------------------------------------------------------------------
  logic signed [D_W-1:0] dv, di;
  logic [D_W-1:0]        dv_mag, step_lim;
  logic                  bad;
  logic [RW-1:0]         bad_d, good_d;
  logic                  valid_flag_d;

  always_comb begin
    dv = signed'({2'b00, bus_q, {F{1'b0}}}) - signed'({2'b00, vavg_q});
    di = D_W'(signed'({cur_q, {F{1'b0}}})) - D_W'(iavg_q);
    dv_mag   = dv[D_W-1] ? D_W'(-dv) : D_W'(dv);
    step_lim = {2'b00, step_mv_q, {F{1'b0}}};
    bad = !ok_q || (bus_q < min_mv_q) || (bus_q > max_mv_q)
          || (primed_q && (dv_mag > step_lim));

    bad_d        = bad_q;
    good_d       = good_q;
    valid_flag_d = valid_flag_q;
    if (bad) begin
      good_d = '0;
      if (bad_q != {RW{1'b1}}) bad_d = bad_q + 1'b1;
      if (!primed_q || (CMP_W'(bad_d) >= CMP_W'(confirm_q))) valid_flag_d = 1'b0;
    end else begin
      bad_d = '0;
      if (good_q != {RW{1'b1}}) good_d = good_q + 1'b1;
      if (!valid_flag_q) valid_flag_d = (CMP_W'(good_d) >= CMP_W'(recover_q));
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier operand select
  // --------------------------------------------------------------------------
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic                   mul_en;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (state_q)
      S_MUL_V: begin
        mul_a = MA_W'(dv);
        mul_b = signed'(MB_W'({1'b0, v_wgt_q}));
      end
      S_MUL_I: begin
        mul_a = MA_W'(di);
        mul_b = signed'(MB_W'({1'b0, i_wgt_q}));
      end
      S_MUL_SH: begin
        mul_a = MA_W'(i_q);
        mul_b = signed'(MB_W'({1'b0, shunt_q}));
      end
      S_MUL_PB: begin
        mul_a = MA_W'(v_q);
        mul_b = MB_W'(i_q);
      end
      S_MUL_PS: begin
        mul_a = MA_W'(src_q);
        mul_b = MB_W'(i_q);
      end
      S_DMUL: begin
        mul_a = signed'(MA_W'({1'b0, abs_q}));
        mul_b = signed'({1'b0, DIV_RECIP});
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= P_W'(mul_a) * P_W'(mul_b);
  end

  // --------------------------------------------------------------------------
  // Average step, rounding and divide correction
  // --------------------------------------------------------------------------
  logic signed [P_W-1:0]  ema_inc;
  logic [VA_W:0]          v_rnd;
  logic signed [IA_W:0]   i_rnd;
  logic [Q_W-1:0]         q0;
  logic [ABS_W:0]         q0_x1000, rem;
  logic signed [Q_W:0]    quot_s;

  always_comb begin
    ema_inc  = (prod_q + (P_W'(1) << (WGT_W - 1))) >>> WGT_W;
    v_rnd    = {1'b0, vavg_q} + ((VA_W+1)'(1) << (F - 1));
    i_rnd    = ((IA_W+1)'(iavg_q) + ((IA_W+1)'(1) << (F - 1))) >>> F;
    q0       = prod_q[DIV_SHIFT +: Q_W];
    q0_x1000 = ({(ABS_W+1)'(q0)} << 10) - ({(ABS_W+1)'(q0)} << 5)
               + ({(ABS_W+1)'(q0)} << 3);
    rem      = {1'b0, abs_q} - q0_x1000;
    quot_s   = neg_q ? -signed'({1'b0, quot_q}) : signed'({1'b0, quot_q});
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc) state_d = S_EVAL;
      S_EVAL: begin
        if (bad) state_d = primed_q ? S_ROUND : S_DONE;
        else     state_d = primed_q ? S_MUL_V : S_ROUND;
      end
      S_MUL_V:  state_d = S_MUL_I;
      S_MUL_I:  state_d = S_UPD_I;
      S_UPD_I:  state_d = S_ROUND;
      S_ROUND:  state_d = S_MUL_SH;
      S_MUL_SH: state_d = S_ABS;
      S_ABS:    state_d = S_DMUL;
      S_DMUL:   state_d = S_DFIX;
      S_DFIX:   state_d = S_DSGN;
      S_DSGN: begin
        case (div_sel_q)
          DIV_SH:  state_d = S_MUL_PB;
          DIV_PB:  state_d = S_MUL_PS;
          default: state_d = S_DONE;
        endcase
      end
      S_MUL_PB: state_d = S_ABS;
      S_MUL_PS: state_d = S_ABS;
      S_DONE:   if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      div_sel_q    <= DIV_SH;
      vavg_q       <= '0;
      iavg_q       <= '0;
      primed_q     <= 1'b0;
      bad_q        <= '0;
      good_q       <= '0;
      valid_flag_q <= 1'b1;
    end else begin
      state_q <= state_d;
      case (state_q)
        // update counters and flag, prime on the first good sample
        S_EVAL: begin
          bad_q        <= bad_d;
          good_q       <= good_d;
          valid_flag_q <= valid_flag_d;
          if (!bad && !primed_q) begin
            vavg_q   <= {bus_q, {F{1'b0}}};
            iavg_q   <= {cur_q, {F{1'b0}}};
            primed_q <= 1'b1;
          end
        end
        S_MUL_I:  vavg_q <= vavg_q + ema_inc[VA_W-1:0];
        S_UPD_I:  iavg_q <= iavg_q + ema_inc[IA_W-1:0];
        S_MUL_SH: div_sel_q <= DIV_SH;
        S_MUL_PB: div_sel_q <= DIV_PB;
        S_MUL_PS: div_sel_q <= DIV_PS;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    // capture the request
    if (in_acc) begin
      ok_q  <= read_ok_i;
      bus_q <= bus_millivolt_i;
      cur_q <= current_milliamp_i;
    end
    case (state_q)
      // zero result for a bad sample before priming
      S_EVAL: begin
        if (bad && !primed_q) begin
          v_q   <= '0;
          i_q   <= '0;
          sh_q  <= '0;
          src_q <= '0;
          pb_q  <= '0;
          ps_q  <= '0;
        end
      end
      S_ROUND: begin
        v_q <= signed'(v_rnd[VA_W:F]);
        i_q <= i_rnd[MA_FLD_W-1:0];
      end
      // take the magnitude of the dividend, keep the shunt product
      S_ABS: begin
        if (div_sel_q == DIV_SH) sh_q <= prod_q[SH_W-1:0];
        abs_q <= prod_q[P_W-1] ? ABS_W'(-prod_q) : ABS_W'(prod_q);
        neg_q <= prod_q[P_W-1];
      end
      // correct the reciprocal estimate by one step
      S_DFIX: quot_q <= (rem >= DIVISOR) ? q0 + 1'b1 : q0;
      S_DSGN: begin
        case (div_sel_q)
          DIV_SH:  src_q <= SRC_W'(v_q) + SRC_W'(quot_s);
          DIV_PB:  pb_q  <= PB_W'(quot_s);
          default: ps_q  <= PS_W'(quot_s);
        endcase
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_bus_q <= v_q[MV_W-1:0];
      out_cur_q <= i_q;
      out_sh_q  <= sh_q;
      out_src_q <= src_q[SRCO_W-1:0];
      out_pb_q  <= pb_q;
      out_ps_q  <= ps_q;
      out_rv_q  <= valid_flag_q;
    end
  end

  assign out_valid_o                 = out_valid_q;
  assign filtered_bus_millivolt_o    = out_bus_q;
  assign filtered_current_milliamp_o = out_cur_q;
  assign shunt_microvolt_o           = out_sh_q;
  assign source_millivolt_o          = out_src_q;
  assign bus_power_milliwatt_o       = out_pb_q;
  assign source_power_milliwatt_o    = out_ps_q;
  assign reading_valid_o             = out_rv_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // averages never become unprimed again
  a_primed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    primed_q |=> primed_q)
    else $error("average primed flag dropped");

  // a good run and a bad run never coexist
  a_runs_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((bad_q != '0) && (good_q != '0)))
    else $error("bad and good run counters both nonzero");

  // an accepted request always goes to evaluation next
  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_EVAL))
    else $error("accepted request not evaluated");

  // before priming, a loaded result is all zero and invalid
  a_unprimed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !primed_q) |=>
      ((out_bus_q == '0) && (out_cur_q == '0) && (out_ps_q == '0) && !out_rv_q))
    else $error("unprimed result not zero");

  // a result is never loaded over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(out_bus_q) && $stable(out_ps_q))
    else $error("stalled result overwritten");

endmodule
